### src/kscq_pkg.sv
// ----------------------------------------------------------------------------
// kscq_pkg
// Shared types, constants and the character-to-scan mapping for the
// keyboard scan code queue.
// ----------------------------------------------------------------------------
package kscq_pkg;

    // Ring geometry: one slot stays unused, so QUEUE_DEPTH-1 words fit
    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned CODE_W      = 8;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CODE_W-1:0] code_t;

    // Request codes
    typedef enum logic [1:0] {
        REQ_PUSH_CHAR = 2'd0,
        REQ_PUSH_WORD = 2'd1,
        REQ_POP       = 2'd2,
        REQ_PEEK      = 2'd3
    } req_type_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    // Scan codes of the fixed mapping
    localparam code_t SCAN_LETTER_A = 8'h1E;
    localparam code_t SCAN_ESC      = 8'h01;
    localparam code_t SCAN_DIGIT_1  = 8'h02;
    localparam code_t SCAN_DIGIT_0  = 8'h0B;
    localparam code_t SCAN_ENTER    = 8'h1C;
    localparam code_t SCAN_BKSP     = 8'h0E;
    localparam code_t SCAN_TAB      = 8'h0F;
    localparam code_t SCAN_SPACE    = 8'h39;
    localparam code_t SCAN_NONE     = 8'h00;

    // Characters of the mapping
    localparam code_t CH_LOWER_A = 8'h61;
    localparam code_t CH_LOWER_Z = 8'h7A;
    localparam code_t CH_UPPER_A = 8'h41;
    localparam code_t CH_UPPER_Z = 8'h5A;
    localparam code_t CH_CASE    = 8'h20;
    localparam code_t CH_ONE     = 8'h31;
    localparam code_t CH_NINE    = 8'h39;
    localparam code_t CH_ZERO    = 8'h30;
    localparam code_t CH_ESC     = 8'h1B;
    localparam code_t CH_CR      = 8'h0D;
    localparam code_t CH_LF      = 8'h0A;
    localparam code_t CH_BS      = 8'h08;
    localparam code_t CH_TAB     = 8'h09;
    localparam code_t CH_SPACE   = 8'h20;

    // Character to scan code; letters folded to upper case first
    function automatic code_t scan_of(input code_t ch);
        code_t c;
        code_t s;
        c = ch;
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
        begin
            c = ch - CH_CASE;
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            s = SCAN_LETTER_A + (c - CH_UPPER_A);
        end
        else if (c >= CH_ONE && c <= CH_NINE)
        begin
            s = SCAN_DIGIT_1 + (c - CH_ONE);
        end
        else if (c == CH_ZERO)
        begin
            s = SCAN_DIGIT_0;
        end
        else if (c == CH_ESC)
        begin
            s = SCAN_ESC;
        end
        else if (c == CH_CR || c == CH_LF)
        begin
            s = SCAN_ENTER;
        end
        else if (c == CH_BS)
        begin
            s = SCAN_BKSP;
        end
        else if (c == CH_TAB)
        begin
            s = SCAN_TAB;
        end
        else if (c == CH_SPACE)
        begin
            s = SCAN_SPACE;
        end
        else
        begin
            s = SCAN_NONE;
        end
        return s;
    endfunction

    // Ring pointer increment with wrap at any depth
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

### src/kscq_req_if.sv
// ----------------------------------------------------------------------------
// kscq_req_if
// Request channel of the key queue: valid/ready and the request item.
// ----------------------------------------------------------------------------
interface kscq_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [kscq_pkg::CODE_W-1:0] key_code;
    logic [kscq_pkg::WORD_W-1:0] key_word;

    modport source (output valid, output req_type, output key_code, output key_word,
                    input ready);
    modport sink   (input valid, input req_type, input key_code, input key_word,
                    output ready);
endinterface

### src/kscq_rsp_if.sv
// ----------------------------------------------------------------------------
// kscq_rsp_if
// Response channel of the key queue: valid/ready and the result item.
// ----------------------------------------------------------------------------
interface kscq_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [kscq_pkg::WORD_W-1:0] queued_word;
    logic                       queue_empty;
    logic                       push_accepted;

    modport source (output valid, output queued_word, output queue_empty,
                    output push_accepted, input ready);
    modport sink   (input valid, input queued_word, input queue_empty,
                    input push_accepted, output ready);
endinterface

### src/kscq_ram.sv
// ----------------------------------------------------------------------------
// kscq_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module kscq_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/keyboard_scan_code_queue_unit.sv
// ----------------------------------------------------------------------------
// keyboard_scan_code_queue_unit
// Ring buffer of 16-bit key words (scan code high, character low) held in a
// RAM, with read and write pointers in flops.
// ----------------------------------------------------------------------------
//  port  | dir | item contents
//  ------+-----+-----------------------------------------------
//  req   | in  | req_type, key_code, key_word
//  rsp   | out | queued_word, queue_empty, push_accepted
//
// Pushes and empty pop/peek go straight to the result register; a pop or peek
// that finds data passes through ST_READ, waiting on the registered RAM read.
// In ST_IDLE, an item is taken if the last result has left or leaves that cycle.
// Reset clears both pointers (ring empty); RAM contents are not cleared.
// A stalled result holds in the output register until rsp.ready.
// ----------------------------------------------------------------------------
module keyboard_scan_code_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    kscq_req_if.sink    req,
    kscq_rsp_if.source  rsp
);

    kscq_pkg::state_t state_reg, state_next;
    kscq_pkg::ptr_t   wr_ptr_reg, wr_ptr_next;
    kscq_pkg::ptr_t   rd_ptr_reg, rd_ptr_next;
    logic             out_valid_reg, out_valid_next;
    kscq_pkg::word_t  word_reg, word_next;
    logic             empty_reg, empty_next;
    logic             acc_reg, acc_next;

    kscq_pkg::req_type_t rtype;
    kscq_pkg::word_t     push_word;
    kscq_pkg::word_t     ram_rdata;
    logic                req_acc;
    logic                ring_empty;
    logic                ring_full;
    logic                is_push;
    logic                do_write;
    logic                do_read;

    assign rtype      = kscq_pkg::req_type_t'(req.req_type);
    assign req_acc    = req.valid && req.ready;
    assign ring_empty = (wr_ptr_reg == rd_ptr_reg);
    assign ring_full  = (kscq_pkg::ptr_inc(wr_ptr_reg) == rd_ptr_reg);
    assign is_push    = (rtype == kscq_pkg::REQ_PUSH_CHAR) ||
                        (rtype == kscq_pkg::REQ_PUSH_WORD);

    // Word to store; a zero character yields a zero word, which is ignored
    always_comb
    begin
        if (rtype == kscq_pkg::REQ_PUSH_CHAR)
        begin
            if (req.key_code == '0)
                push_word = '0;
            else
                push_word = {kscq_pkg::scan_of(req.key_code), req.key_code};
        end
        else
        begin
            push_word = req.key_word;
        end
    end

    assign do_write = req_acc && is_push && (push_word != '0) && !ring_full;
    assign do_read  = req_acc && !is_push && !ring_empty;

    // Ready: sequencer idle and the output register free or emptying
    assign req.ready = (state_reg == kscq_pkg::ST_IDLE) && (!out_valid_reg || rsp.ready);

    kscq_ram #(
        .WIDTH (kscq_pkg::WORD_W),
        .DEPTH (kscq_pkg::QUEUE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (do_write),
        .waddr (wr_ptr_reg),
        .wdata (push_word),
        .re    (do_read),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Next state, pointers and result register
    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        word_next      = word_reg;
        empty_next     = empty_reg;
        acc_next       = acc_reg;
        unique case (state_reg)
            kscq_pkg::ST_IDLE:
            begin
                if (req_acc)
                begin
                    if (is_push)
                    begin
                        out_valid_next = 1'b1;
                        word_next      = '0;
                        empty_next     = 1'b0;
                        acc_next       = do_write;
                        if (do_write)
                            wr_ptr_next = kscq_pkg::ptr_inc(wr_ptr_reg);
                    end
                    else if (ring_empty)
                    begin
                        out_valid_next = 1'b1;
                        word_next      = '0;
                        empty_next     = 1'b1;
                        acc_next       = 1'b0;
                    end
                    else
                    begin
                        state_next = kscq_pkg::ST_READ;
                        if (rtype == kscq_pkg::REQ_POP)
                            rd_ptr_next = kscq_pkg::ptr_inc(rd_ptr_reg);
                    end
                end
            end
            kscq_pkg::ST_READ:
            begin
                // RAM data for the oldest word has arrived
                state_next     = kscq_pkg::ST_IDLE;
                out_valid_next = 1'b1;
                word_next      = ram_rdata;
                empty_next     = 1'b0;
                acc_next       = 1'b0;
            end
            default:
            begin
                state_next = kscq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kscq_pkg::ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        empty_reg <= empty_next;
        acc_reg   <= acc_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.queued_word   = word_reg;
    assign rsp.queue_empty   = empty_reg;
    assign rsp.push_accepted = acc_reg;

    // Checks
    a_read_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kscq_pkg::ST_READ |-> !out_valid_reg)
        else $error("result pending during ring read");

    a_read_enters: assert property (@(posedge clk) disable iff (!rst_n)
        do_read |=> state_reg == kscq_pkg::ST_READ)
        else $error("ring read did not start");

    a_read_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kscq_pkg::ST_READ |=> out_valid_reg && state_reg == kscq_pkg::ST_IDLE)
        else $error("ring read did not produce a result");

    a_write_moves: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |=> wr_ptr_reg != $past(wr_ptr_reg) && acc_reg)
        else $error("stored push did not advance write pointer");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        ring_full |-> !do_write)
        else $error("write into full ring");

endmodule
